/* rtl/c65x_pkg.sv */
// Shared types and constants for the 6502 execute unit.
// Used by c65x_alu and cpu6502_execute_unit; depends on nothing.
package c65x_pkg;

  // Mnemonic index, alphabetical order
  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11,
    OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15,
    OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23,
    OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27,
    OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31,
    OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35,
    OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43,
    OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47,
    OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51,
    OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55
  } cmd_t;

  // Status bit positions: N V 1 B D I Z C
  localparam int unsigned FL_N = 7;
  localparam int unsigned FL_V = 6;
  localparam int unsigned FL_U = 5;
  localparam int unsigned FL_B = 4;
  localparam int unsigned FL_D = 3;
  localparam int unsigned FL_I = 2;
  localparam int unsigned FL_Z = 1;
  localparam int unsigned FL_C = 0;

  // Bits 5 and 4 are kept across pulls; PHP sets both
  localparam logic [7:0] PULL_KEEP  = 8'h30;
  localparam logic [7:0] STACK_PAGE = 8'h01;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] p;
    logic [7:0] sp;
  } regs_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        acc_mode;
    logic [7:0]  operand;
    logic [15:0] eff_addr;
    logic [15:0] instr_pc;
    logic [7:0]  pop_first;
    logic [7:0]  pop_second;
    logic [7:0]  pop_third;
  } item_t;

  typedef struct packed {
    logic        write_en;
    logic        is_push;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    regs_t       snap;
    logic        pc_redirect;
    logic [15:0] new_pc;
    logic        last;
  } res_t;

endpackage

/* rtl/c65x_alu.sv */
// Combinational execute logic: one instruction against the register file.
// Depends on c65x_pkg for item, register and result types.
module c65x_alu
  import c65x_pkg::*;
(
  input  item_t it,
  input  regs_t regs,
  output regs_t nxt,
  output res_t  res0,
  output res_t  res1,
  output logic  two
);

  logic [7:0]  add_num;
  logic [8:0]  sum;
  logic        ovf;
  logic [7:0]  cmp_reg;
  logic [8:0]  diff;
  logic [7:0]  sh_in;
  logic [7:0]  sh_out;
  logic [7:0]  rmw;
  logic [15:0] br_target;
  logic [15:0] ret_pc;
  logic        cond;
  logic        redir;
  logic [15:0] npc;
  logic        we;
  logic        push;
  logic [15:0] waddr;
  logic [7:0]  wdata;

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q       = p;
    q[FL_N] = v[7];
    q[FL_Z] = (v == 8'h00);
    return q;
  endfunction

  // Shared datapath pieces
  assign add_num   = (it.cmd == OP_SBC) ? ~it.operand : it.operand;
  assign sum       = {1'b0, regs.a} + {1'b0, add_num} + {8'h00, regs.p[FL_C]};
  assign ovf       = (~(regs.a[7] ^ add_num[7])) & (regs.a[7] ^ sum[7]);
  assign cmp_reg   = (it.cmd == OP_CPX) ? regs.x : (it.cmd == OP_CPY) ? regs.y : regs.a;
  assign diff      = {1'b0, cmp_reg} - {1'b0, it.operand};
  assign sh_in     = it.acc_mode ? regs.a : it.operand;
  assign rmw       = (it.cmd == OP_DEC) ? it.operand - 8'd1 : it.operand + 8'd1;
  assign br_target = it.instr_pc + 16'd2 + {{8{it.operand[7]}}, it.operand};
  assign ret_pc    = it.instr_pc + 16'd3;

  // Shift and rotate unit
  always_comb begin
    case (it.cmd)
      OP_ASL:  sh_out = {sh_in[6:0], 1'b0};
      OP_LSR:  sh_out = {1'b0, sh_in[7:1]};
      OP_ROL:  sh_out = {sh_in[6:0], regs.p[FL_C]};
      OP_ROR:  sh_out = {regs.p[FL_C], sh_in[7:1]};
      default: sh_out = sh_in;
    endcase
  end

  // Decode and execute
  always_comb begin
    nxt   = regs;
    res0  = '0;
    res1  = '0;
    two   = 1'b0;
    cond  = 1'b0;
    redir = 1'b0;
    npc   = '0;
    we    = 1'b0;
    push  = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (it.cmd) inside
      OP_ADC, OP_SBC: begin
        nxt.a       = sum[7:0];
        nxt.p[FL_C] = sum[8];
        nxt.p[FL_V] = ovf;
        nxt.p       = set_nz(nxt.p, sum[7:0]);
      end
      OP_AND: begin
        nxt.a = regs.a & it.operand;
        nxt.p = set_nz(regs.p, nxt.a);
      end
      OP_ORA: begin
        nxt.a = regs.a | it.operand;
        nxt.p = set_nz(regs.p, nxt.a);
      end
      OP_EOR: begin
        nxt.a = regs.a ^ it.operand;
        nxt.p = set_nz(regs.p, nxt.a);
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        nxt.p[FL_C] = (it.cmd == OP_ASL || it.cmd == OP_ROL) ? sh_in[7] : sh_in[0];
        nxt.p       = set_nz(nxt.p, sh_out);
        if (it.acc_mode) begin
          nxt.a = sh_out;
        end else begin
          we    = 1'b1;
          waddr = it.eff_addr;
          wdata = sh_out;
        end
      end
      OP_BCC: cond = ~regs.p[FL_C];
      OP_BCS: cond = regs.p[FL_C];
      OP_BEQ: cond = regs.p[FL_Z];
      OP_BNE: cond = ~regs.p[FL_Z];
      OP_BMI: cond = regs.p[FL_N];
      OP_BPL: cond = ~regs.p[FL_N];
      OP_BVC: cond = ~regs.p[FL_V];
      OP_BVS: cond = regs.p[FL_V];
      OP_BIT: begin
        nxt.p[FL_Z] = ((regs.a & it.operand) == 8'h00);
        nxt.p[FL_V] = it.operand[6];
        nxt.p[FL_N] = it.operand[7];
      end
      OP_CLC: nxt.p[FL_C] = 1'b0;
      OP_CLD: nxt.p[FL_D] = 1'b0;
      OP_CLI: nxt.p[FL_I] = 1'b0;
      OP_CLV: nxt.p[FL_V] = 1'b0;
      OP_SEC: nxt.p[FL_C] = 1'b1;
      OP_SED: nxt.p[FL_D] = 1'b1;
      OP_SEI: nxt.p[FL_I] = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        nxt.p[FL_N] = diff[7];
        nxt.p[FL_Z] = (cmp_reg == it.operand);
        nxt.p[FL_C] = ~diff[8];
      end
      OP_DEC, OP_INC: begin
        nxt.p = set_nz(regs.p, rmw);
        we    = 1'b1;
        waddr = it.eff_addr;
        wdata = rmw;
      end
      OP_DEX: begin
        nxt.x = regs.x - 8'd1;
        nxt.p = set_nz(regs.p, nxt.x);
      end
      OP_DEY: begin
        nxt.y = regs.y - 8'd1;
        nxt.p = set_nz(regs.p, nxt.y);
      end
      OP_INX: begin
        nxt.x = regs.x + 8'd1;
        nxt.p = set_nz(regs.p, nxt.x);
      end
      OP_INY: begin
        nxt.y = regs.y + 8'd1;
        nxt.p = set_nz(regs.p, nxt.y);
      end
      OP_JMP: begin
        redir = 1'b1;
        npc   = it.eff_addr;
      end
      OP_JSR: begin
        // Two pushes: return address high byte, then low byte
        two                = 1'b1;
        nxt.sp             = regs.sp - 8'd2;
        res0.write_en      = 1'b1;
        res0.is_push       = 1'b1;
        res0.write_addr    = {STACK_PAGE, regs.sp};
        res0.write_data    = ret_pc[15:8];
        res0.snap          = regs;
        res0.snap.sp       = regs.sp - 8'd1;
        res1.write_en      = 1'b1;
        res1.is_push       = 1'b1;
        res1.write_addr    = {STACK_PAGE, res0.snap.sp};
        res1.write_data    = ret_pc[7:0];
        res1.snap          = nxt;
        res1.pc_redirect   = 1'b1;
        res1.new_pc        = it.eff_addr;
        res1.last          = 1'b1;
      end
      OP_LDA: begin
        nxt.a = it.operand;
        nxt.p = set_nz(regs.p, it.operand);
      end
      OP_LDX: begin
        nxt.x = it.operand;
        nxt.p = set_nz(regs.p, it.operand);
      end
      OP_LDY: begin
        nxt.y = it.operand;
        nxt.p = set_nz(regs.p, it.operand);
      end
      OP_PHA, OP_PHP: begin
        if (it.cmd == OP_PHP) begin
          nxt.p = regs.p | PULL_KEEP;
        end
        we     = 1'b1;
        push   = 1'b1;
        waddr  = {STACK_PAGE, regs.sp};
        wdata  = (it.cmd == OP_PHA) ? regs.a : nxt.p;
        nxt.sp = regs.sp - 8'd1;
      end
      OP_PLA: begin
        nxt.sp = regs.sp + 8'd1;
        nxt.a  = it.pop_first;
        nxt.p  = set_nz(regs.p, it.pop_first);
      end
      OP_PLP: begin
        nxt.sp = regs.sp + 8'd1;
        nxt.p  = (it.pop_first & ~PULL_KEEP) | (regs.p & PULL_KEEP);
      end
      OP_RTI: begin
        nxt.sp = regs.sp + 8'd3;
        nxt.p  = (it.pop_first & ~PULL_KEEP) | (regs.p & PULL_KEEP);
        redir  = 1'b1;
        npc    = {it.pop_third, it.pop_second};
      end
      OP_RTS: begin
        nxt.sp = regs.sp + 8'd2;
        redir  = 1'b1;
        npc    = {it.pop_second, it.pop_first};
      end
      OP_STA: begin
        we    = 1'b1;
        waddr = it.eff_addr;
        wdata = regs.a;
      end
      OP_STX: begin
        we    = 1'b1;
        waddr = it.eff_addr;
        wdata = regs.x;
      end
      OP_STY: begin
        we    = 1'b1;
        waddr = it.eff_addr;
        wdata = regs.y;
      end
      OP_TAX: begin
        nxt.x = regs.a;
        nxt.p = set_nz(regs.p, regs.a);
      end
      OP_TAY: begin
        nxt.y = regs.a;
        nxt.p = set_nz(regs.p, regs.a);
      end
      OP_TSX: begin
        nxt.x = regs.sp;
        nxt.p = set_nz(regs.p, regs.sp);
      end
      OP_TXA: begin
        nxt.a = regs.x;
        nxt.p = set_nz(regs.p, regs.x);
      end
      OP_TXS: nxt.sp = regs.x;
      OP_TYA: begin
        nxt.a = regs.y;
        nxt.p = set_nz(regs.p, regs.y);
      end
      // BRK, NOP and unused codes leave everything alone
      default: ;
    endcase

    // Taken branch
    if (cond) begin
      redir = 1'b1;
      npc   = br_target;
    end

    // Single result for everything but JSR
    if (!two) begin
      res0.write_en    = we;
      res0.is_push     = push;
      res0.write_addr  = waddr;
      res0.write_data  = wdata;
      res0.snap        = nxt;
      res0.pc_redirect = redir;
      res0.new_pc      = npc;
      res0.last        = 1'b1;
    end
  end

endmodule

/* rtl/cpu6502_execute_unit.sv */
// 6502 execute unit, top level: input register, register file, result register.
// Depends on c65x_pkg and c65x_alu.
// Each item is registered at the input, executed by c65x_alu, and its result is registered.
// Throughput: one item per cycle while out_ready does not stall the result register;
//   after a JSR the next item waits while JSR's second push leaves through the single result register.
// Reset: A, X, Y, S and P clear to zero; the input and result stages empty.
module cpu6502_execute_unit
  import c65x_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [5:0]  cmd,
  input  logic        acc_mode,
  input  logic [7:0]  operand,
  input  logic [15:0] eff_addr,
  input  logic [15:0] instr_pc,
  input  logic [7:0]  pop_first,
  input  logic [7:0]  pop_second,
  input  logic [7:0]  pop_third,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_en,
  output logic        is_push,
  output logic [15:0] write_addr,
  output logic [7:0]  write_data,
  output logic [7:0]  acc_out,
  output logic [7:0]  x_out,
  output logic [7:0]  y_out,
  output logic [7:0]  status_out,
  output logic [7:0]  sp_out,
  output logic        pc_redirect,
  output logic [15:0] new_pc,
  output logic        last
);

  logic  in_full;
  item_t in_item;
  regs_t arch;
  regs_t arch_next;
  res_t  res_a;
  res_t  res_b;
  logic  res_two;
  res_t  out_res;
  logic  sec_valid;
  res_t  sec_res;
  logic  out_free;
  logic  exec_fire;

  c65x_alu u_alu (
    .it   (in_item),
    .regs (arch),
    .nxt  (arch_next),
    .res0 (res_a),
    .res1 (res_b),
    .two  (res_two)
  );

  // Handshake control
  assign out_free  = ~out_valid | out_ready;
  assign exec_fire = in_full & ~sec_valid & out_free;
  assign in_ready  = ~in_full | exec_fire;

  // Control state and register file
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
      arch      <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (exec_fire) begin
        in_full <= 1'b0;
      end
      if (exec_fire) begin
        arch <= arch_next;
      end
      if (out_free) begin
        if (sec_valid) begin
          out_valid <= 1'b1;
          sec_valid <= 1'b0;
        end else if (exec_fire) begin
          out_valid <= 1'b1;
          sec_valid <= res_two;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item <= '{cmd: cmd_t'(cmd), acc_mode: acc_mode, operand: operand,
                   eff_addr: eff_addr, instr_pc: instr_pc, pop_first: pop_first,
                   pop_second: pop_second, pop_third: pop_third};
    end
    if (out_free && (sec_valid || exec_fire)) begin
      out_res <= sec_valid ? sec_res : res_a;
    end
    if (exec_fire) begin
      sec_res <= res_b;
    end
  end

  // Drive result ports
  assign write_en    = out_res.write_en;
  assign is_push     = out_res.is_push;
  assign write_addr  = out_res.write_addr;
  assign write_data  = out_res.write_data;
  assign acc_out     = out_res.snap.a;
  assign x_out       = out_res.snap.x;
  assign y_out       = out_res.snap.y;
  assign status_out  = out_res.snap.p;
  assign sp_out      = out_res.snap.sp;
  assign pc_redirect = out_res.pc_redirect;
  assign new_pc      = out_res.new_pc;
  assign last        = out_res.last;

`ifndef SYNTHESIS
  a_sec_needs_out: assert property (@(posedge clk) disable iff (rst)
    sec_valid |-> out_valid)
    else $error("second result pending with empty result register");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (sec_valid && in_full) |-> !in_ready)
    else $error("input taken while second push pending");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && last))
    else $error("second push did not follow the first");

  a_first_is_push: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (write_en && is_push && !pc_redirect))
    else $error("non-final result is not a plain push");
`endif

endmodule
